>>> sv/hres_pkg.sv
// Shared constants and codes for the explicit heat rod step block.
package hres_pkg;

  localparam int CELLS_DEFAULT = 32;
  localparam int TEMP_W        = 16;
  localparam int ALPHA_W       = 16;
  localparam int REG_IDX_W     = 2;
  localparam int CELL_IDX_W    = 6;

  localparam logic signed [TEMP_W-1:0] LEFT_RESET    = 16'sd25600;
  localparam logic signed [TEMP_W-1:0] RIGHT_RESET   = 16'sd6400;
  localparam logic signed [TEMP_W-1:0] INIT_RESET    = 16'sd6400;
  localparam logic        [ALPHA_W-1:0] ALPHA_RESET  = 16'd6554;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEFT_BOUNDARY  = 2'd0,
    REG_RIGHT_BOUNDARY = 2'd1,
    REG_INITIAL_TEMP   = 2'd2,
    REG_ALPHA          = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_INIT = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

endpackage

>>> sv/heat_rod_explicit_step_top.sv
// Top level of the explicit heat rod step block: cell memory, sequencer and report port.
//
// The cell temperatures live in one single-port-write memory with a registered read.
// An init item writes initial_temp into every cell, one cell per cycle. A step item
// sweeps the memory once, one read per cycle, and writes each updated cell once its
// right neighbor's read has passed the read data register and the update pipeline's
// product register. With report set, the cells then stream out after either item at one
// transfer per cycle when the output is not stalled. The block takes one item at a time
// and holds the input stalled until it is back in idle.
// Configuration writes take effect at once and belong between items.
module heat_rod_explicit_step_top import hres_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [TEMP_W-1:0]           cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic                        report,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CELL_IDX_W-1:0]       cell_index,
  output logic signed [TEMP_W-1:0]    temperature,
  output logic                        last
);

  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INIT   = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [TEMP_W-1:0] left_boundary;
  logic signed [TEMP_W-1:0] right_boundary;
  logic signed [TEMP_W-1:0] initial_temp;
  logic [ALPHA_W-1:0]       alpha;

  logic signed [TEMP_W-1:0] mem [CELLS];
  logic signed [TEMP_W-1:0] rd_data;
  logic                     rd_en;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [TEMP_W-1:0] mem_wdata;

  logic [CNT_W-1:0]         cnt;
  logic                     rep;
  logic                     cnt_live;

  logic                     arr_valid;
  logic [CNT_W-1:0]         arr_idx;
  logic signed [TEMP_W-1:0] win_l;
  logic signed [TEMP_W-1:0] win_c;

  logic                     cmp_valid;
  logic [IDX_W-1:0]         cmp_idx;
  logic signed [TEMP_W-1:0] cmp_left;
  logic signed [TEMP_W-1:0] cmp_right;
  logic                     upd_valid;
  logic [IDX_W-1:0]         upd_idx;
  logic signed [TEMP_W-1:0] upd_data;

  logic                     pending;
  logic [IDX_W-1:0]         pend_idx;
  logic                     move;
  logic                     accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_boundary  <= LEFT_RESET;
      right_boundary <= RIGHT_RESET;
      initial_temp   <= INIT_RESET;
      alpha          <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_BOUNDARY:  left_boundary  <= cfg_data;
        REG_RIGHT_BOUNDARY: right_boundary <= cfg_data;
        REG_INITIAL_TEMP:   initial_temp   <= cfg_data;
        REG_ALPHA:          alpha          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cnt_live = (cnt < CNT_W'(CELLS));
  assign move     = pending && (!out_valid || !out_stall);

  always_comb begin
    rd_en = 1'b0;
    unique case (state)
      ST_STEP:   rd_en = cnt_live;
      ST_REPORT: rd_en = cnt_live && (!pending || move);
      default:   rd_en = 1'b0;
    endcase
  end

  // memory write port: init sweep or update pipeline
  always_comb begin
    if (state == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[IDX_W-1:0];
      mem_wdata = initial_temp;
    end else begin
      mem_we    = upd_valid;
      mem_waddr = upd_idx;
      mem_wdata = upd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[cnt[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind_t'(kind) == KIND_INIT) ? ST_INIT : ST_STEP;
        end
      end
      ST_INIT: begin
        if (cnt == CNT_W'(CELLS - 1)) begin
          state_next = rep ? ST_REPORT : ST_IDLE;
        end
      end
      ST_STEP: begin
        if (cnt == CNT_W'(CELLS)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!arr_valid && !upd_valid) begin
          state_next = rep ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (!cnt_live && !pending) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rep       <= 1'b0;
      arr_valid <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state     <= state_next;
      arr_valid <= (state == ST_STEP);
      if (accept) begin
        rep <= report;
      end
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_INIT || state == ST_STEP || rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (rd_en && state == ST_REPORT) begin
        pending <= 1'b1;
      end else if (move) begin
        pending <= 1'b0;
      end
    end
    arr_idx <= cnt;
    if (rd_en) begin
      pend_idx <= cnt[IDX_W-1:0];
    end
  end

  // neighbor window over the old values
  always_ff @(posedge clk) begin
    if (arr_valid && arr_idx < CNT_W'(CELLS)) begin
      win_l <= win_c;
      win_c <= rd_data;
    end
  end

  assign cmp_valid = arr_valid && (arr_idx != '0);
  assign cmp_idx   = IDX_W'(arr_idx - CNT_W'(1));
  assign cmp_left  = (arr_idx == CNT_W'(1)) ? left_boundary : win_l;
  assign cmp_right = (arr_idx == CNT_W'(CELLS)) ? right_boundary : rd_data;

  hres_update #(
    .IDX_W (IDX_W)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .cmp_valid (cmp_valid),
    .cmp_idx   (cmp_idx),
    .left      (cmp_left),
    .centre    (win_c),
    .right     (cmp_right),
    .alpha     (alpha),
    .wr_valid  (upd_valid),
    .wr_idx    (upd_idx),
    .wr_data   (upd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      cell_index  <= CELL_IDX_W'(pend_idx);
      temperature <= rd_data;
      last        <= (pend_idx == IDX_W'(CELLS - 1));
    end
  end

endmodule

>>> sv/hres_update.sv
// Cell update pipeline: laplacian times alpha, round half up, saturating add.
module hres_update import hres_pkg::*; #(
  parameter int IDX_W = $clog2(CELLS_DEFAULT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmp_valid,
  input  logic [IDX_W-1:0]          cmp_idx,
  input  logic signed [TEMP_W-1:0]  left,
  input  logic signed [TEMP_W-1:0]  centre,
  input  logic signed [TEMP_W-1:0]  right,
  input  logic [ALPHA_W-1:0]        alpha,
  output logic                      wr_valid,
  output logic [IDX_W-1:0]          wr_idx,
  output logic signed [TEMP_W-1:0]  wr_data
);

  localparam int LAP_W  = TEMP_W + 2;
  localparam int PROD_W = LAP_W + ALPHA_W + 1;
  localparam int DEL_W  = PROD_W - 16;
  localparam int SUM_W  = DEL_W + 1;

  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [TEMP_W-1:0] cen;
  logic                     valid;
  logic [IDX_W-1:0]         idx;
  logic signed [PROD_W-1:0] biased;
  logic signed [DEL_W-1:0]  delta;
  logic signed [SUM_W-1:0]  sum;

  assign lap = LAP_W'(left) - (LAP_W'(centre) <<< 1) + LAP_W'(right);
  assign prod_next = PROD_W'(lap) * PROD_W'($signed({1'b0, alpha}));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmp_valid;
    end
    prod <= prod_next;
    cen  <= centre;
    idx  <= cmp_idx;
  end

  assign biased = prod + PROD_W'(32768);
  assign delta  = biased[PROD_W-1:16];
  assign sum    = SUM_W'(cen) + SUM_W'(delta);

  always_comb begin
    if (sum > SUM_W'(32767)) begin
      wr_data = 16'sh7FFF;
    end else if (sum < -SUM_W'(32768)) begin
      wr_data = 16'sh8000;
    end else begin
      wr_data = sum[TEMP_W-1:0];
    end
  end

  assign wr_valid = valid;
  assign wr_idx   = idx;

endmodule
